// ===== design/ibmw_pkg.sv =====
// shared types, constants and helpers for the indirect block map walker
package ibmw_pkg;

    localparam int unsigned DIRECT_POINTERS = 12;
    localparam int unsigned LIM_W = 43;
    localparam int unsigned IDX_W = 14;

    typedef enum logic [1:0] {
        KIND_SLOT    = 2'd0,
        KIND_WORD    = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_IGNORED = 2'd3
    } kind_t;

    typedef struct packed {
        logic        walking;
        logic [1:0]  levels_left;
        logic [31:0] residual;
    } walk_t;

    typedef struct packed {
        kind_t             kind;
        logic [31:0]       target_block;
        logic [IDX_W-1:0]  word_index;
        logic [31:0]       physical_block;
        logic              out_of_range;
    } res_t;

    // pointer index width: 8 plus the clamped log block size
    function automatic logic [3:0] ptr_shift(input logic [2:0] log_bs);
        logic [2:0] l;
        begin
            l = (log_bs > 3'd6) ? 3'd6 : log_bs;
            return 4'd8 + {1'b0, l};
        end
    endfunction

endpackage

// ===== design/ibmw_classify.sv =====
// range classification of a new lookup request
module ibmw_classify (
    input  logic [31:0]    logical_block,
    input  logic [3:0]     sh,
    output ibmw_pkg::res_t res,
    output ibmw_pkg::walk_t walk
);
    import ibmw_pkg::*;

    logic [LIM_W-1:0] bn;
    logic [LIM_W-1:0] lim1;
    logic [LIM_W-1:0] lim2;
    logic [LIM_W-1:0] lim3;
    logic [LIM_W-1:0] d1;
    logic [LIM_W-1:0] d2;
    logic [LIM_W-1:0] d3;
    logic [4:0]       sh2;
    logic [5:0]       sh3;

    always_comb
    begin
        sh2  = {sh, 1'b0};
        sh3  = {2'b00, sh} + {1'b0, sh2};
        bn   = LIM_W'(logical_block);
        lim1 = LIM_W'(1) << sh;
        lim2 = LIM_W'(1) << sh2;
        lim3 = LIM_W'(1) << sh3;
        d1   = bn - LIM_W'(DIRECT_POINTERS);
        d2   = d1 - lim1;
        d3   = d2 - lim2;

        res.kind           = KIND_SLOT;
        res.target_block   = '0;
        res.word_index     = '0;
        res.physical_block = '0;
        res.out_of_range   = 1'b0;
        walk.walking       = 1'b1;
        walk.levels_left   = 2'd0;
        walk.residual      = '0;

        priority if (bn < LIM_W'(DIRECT_POINTERS))
        begin
            res.word_index = IDX_W'(logical_block);
        end
        else if (d1 < lim1)
        begin
            res.word_index   = IDX_W'(DIRECT_POINTERS);
            walk.levels_left = 2'd1;
            walk.residual    = d1[31:0];
        end
        else if (d2 < lim2)
        begin
            res.word_index   = IDX_W'(DIRECT_POINTERS + 1);
            walk.levels_left = 2'd2;
            walk.residual    = d2[31:0];
        end
        else if (d3 < lim3)
        begin
            res.word_index   = IDX_W'(DIRECT_POINTERS + 2);
            walk.levels_left = 2'd3;
            walk.residual    = d3[31:0];
        end
        else
        begin
            res.kind         = KIND_DONE;
            res.out_of_range = 1'b1;
            walk.walking     = 1'b0;
        end
    end

endmodule

// ===== design/ibmw_step.sv =====
// one level step of a walk on a returned pointer word
module ibmw_step (
    input  logic [31:0]     read_word,
    input  logic            read_failed,
    input  logic [3:0]      sh,
    input  ibmw_pkg::walk_t walk_in,
    output ibmw_pkg::res_t  res,
    output ibmw_pkg::walk_t walk
);
    import ibmw_pkg::*;

    logic [4:0]       amt;
    logic [31:0]      shifted;
    logic [IDX_W:0]   mask_wide;
    logic [IDX_W-1:0] mask;

    always_comb
    begin
        unique case (walk_in.levels_left)
            2'd2:    amt = {1'b0, sh};
            2'd3:    amt = {sh, 1'b0};
            default: amt = 5'd0;
        endcase
        shifted   = walk_in.residual >> amt;
        mask_wide = ((IDX_W+1)'(1) << sh) - (IDX_W+1)'(1);
        mask      = mask_wide[IDX_W-1:0];

        res.kind           = KIND_DONE;
        res.target_block   = '0;
        res.word_index     = '0;
        res.physical_block = '0;
        res.out_of_range   = 1'b0;
        walk.walking       = 1'b0;
        walk.levels_left   = 2'd0;
        walk.residual      = '0;

        priority if (!walk_in.walking)
        begin
            res.kind = KIND_IGNORED;
            walk     = walk_in;
        end
        else if (read_failed)
        begin
            // failure ends the walk with a hole
        end
        else if (walk_in.levels_left == 2'd0)
        begin
            res.physical_block = read_word;
        end
        else if (read_word == 32'd0)
        begin
            // zero pointer at an indirect level
        end
        else
        begin
            res.kind         = KIND_WORD;
            res.target_block = read_word;
            res.word_index   = shifted[IDX_W-1:0] & mask;
            walk.walking     = 1'b1;
            walk.levels_left = walk_in.levels_left - 2'd1;
            walk.residual    = walk_in.residual;
        end
    end

endmodule

// ===== design/indirect_block_map_walker.sv =====
// Maps a file-relative logical block to a physical block by walking the
// direct / single / double / triple indirect pointer tree, one pointer word
// per request. A lookup (req_type 0) answers with the inode slot to read; each
// returned word (req_type 1) answers with the next block word to read or with
// the final mapping. Every request gives exactly one result. Requests are
// taken one per cycle unless the output stalls: a request is latched in an
// input register, resolved by one range compare or one shift-and-mask level
// step, and lands in an output register when it advances; the walk state
// updates with it, so back-to-back requests see each other's state. log_block_size
// is always ready and should only be written while no request is in flight.
module indirect_block_map_walker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] logical_block,
    input  logic [31:0] read_word,
    input  logic        read_failed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] target_block,
    output logic [13:0] word_index,
    output logic [31:0] physical_block,
    output logic        out_of_range
);
    import ibmw_pkg::*;

    logic [2:0]  log_bs_reg;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic        hold_type_reg;
    logic [31:0] hold_block_reg;
    logic [31:0] hold_word_reg;
    logic        hold_failed_reg;
    walk_t       walk_reg;
    walk_t       walk_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        out_reg;
    res_t        out_next;

    logic        accept;
    logic        advance;
    logic [3:0]  sh;
    res_t        cls_res;
    walk_t       cls_walk;
    res_t        stp_res;
    walk_t       stp_walk;

    assign cfg_ready = 1'b1;
    assign sh        = ptr_shift(log_bs_reg);
    assign advance   = hold_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = hold_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;

    ibmw_classify u_classify (
        .logical_block (hold_block_reg),
        .sh            (sh),
        .res           (cls_res),
        .walk          (cls_walk)
    );

    ibmw_step u_step (
        .read_word   (hold_word_reg),
        .read_failed (hold_failed_reg),
        .sh          (sh),
        .walk_in     (walk_reg),
        .res         (stp_res),
        .walk        (stp_walk)
    );

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (advance)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end

        walk_next      = walk_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (hold_type_reg)
            begin
                out_next  = stp_res;
                walk_next = stp_walk;
            end
            else
            begin
                out_next  = cls_res;
                walk_next = cls_walk;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_bs_reg     <= 3'd0;
            hold_valid_reg <= 1'b0;
            walk_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                log_bs_reg <= cfg_data;
            end
            hold_valid_reg <= hold_valid_next;
            walk_reg       <= walk_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_type_reg   <= req_type;
            hold_block_reg  <= logical_block;
            hold_word_reg   <= read_word;
            hold_failed_reg <= read_failed;
        end
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_reg.kind;
    assign target_block   = out_reg.target_block;
    assign word_index     = out_reg.word_index;
    assign physical_block = out_reg.physical_block;
    assign out_of_range   = out_reg.out_of_range;

    // an idle walker carries no leftover level or offset
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !walk_reg.walking |-> (walk_reg.levels_left == 2'd0 && walk_reg.residual == 32'd0))
        else $error("idle walker holds stale walk state");

    // a block word request keeps the walk alive until it is taken
    a_word_walking: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_WORD) |-> walk_reg.walking)
        else $error("block word request issued without an active walk");

    // an ignored word means no walk was running
    a_ignored_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_IGNORED) |-> !walk_reg.walking)
        else $error("word ignored while a walk is active");

    // out of range only ever comes with a done result and no mapping
    a_oor_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.out_of_range)
            |-> (out_reg.kind == KIND_DONE && out_reg.physical_block == 32'd0))
        else $error("out of range flag on a non-done result");

endmodule
